// ----- src/uart_rb_pkg.sv -----
// Shared types and constants for the UART ring buffer pair.
`timescale 1ns / 1ps
`default_nettype none

package uart_rb_pkg;

  typedef enum logic [1:0] {
    ACT_RX_BYTE    = 2'd0,
    ACT_HOST_READ  = 2'd1,
    ACT_HOST_WRITE = 2'd2,
    ACT_TX_READY   = 2'd3
  } action_t;

  localparam int unsigned ByteW = 8;

  // collected error flag bit positions
  localparam int unsigned FlagFrame    = 0;
  localparam int unsigned FlagOverrun  = 1;
  localparam int unsigned FlagParity   = 2;
  localparam int unsigned FlagOverflow = 3;
  localparam int unsigned FlagW        = 4;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [FlagW-1:0] flags_t;

  // decision made at input transfer, waiting for the buffer read data
  typedef struct packed {
    logic   read_valid;
    logic   no_data;
    flags_t flags;
    logic   line_valid;
    logic   write_accepted;
    logic   sender_active;
  } stage_t;

endpackage

`default_nettype wire

// ----- src/uart_rb_if.sv -----
// Valid/ready channel interfaces for the event input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface uart_rb_in_if;
  logic                  valid;
  logic                  ready;
  uart_rb_pkg::action_t  action;
  uart_rb_pkg::byte_t    data_byte;
  logic                  line_frame_error;
  logic                  line_overrun;
  logic                  line_parity_error;

  modport source (
    output valid, action, data_byte, line_frame_error, line_overrun, line_parity_error,
    input  ready
  );
  modport sink (
    input  valid, action, data_byte, line_frame_error, line_overrun, line_parity_error,
    output ready
  );
endinterface

interface uart_rb_out_if;
  logic               valid;
  logic               ready;
  logic               read_valid;
  logic               no_data;
  uart_rb_pkg::byte_t read_data;
  logic               frame_flag;
  logic               overrun_flag;
  logic               parity_flag;
  logic               overflow_flag;
  logic               line_valid;
  uart_rb_pkg::byte_t line_data;
  logic               write_accepted;
  logic               sender_active;

  modport source (
    output valid, read_valid, no_data, read_data, frame_flag, overrun_flag, parity_flag,
           overflow_flag, line_valid, line_data, write_accepted, sender_active,
    input  ready
  );
  modport sink (
    input  valid, read_valid, no_data, read_data, frame_flag, overrun_flag, parity_flag,
           overflow_flag, line_valid, line_data, write_accepted, sender_active,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/uart_rb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module uart_rb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/uart_rb_top.sv -----
// Top level: receive and transmit ring buffers with pointer and flag control.
// Path: an input transfer loads the buffer-read stage, which then loads the result register
//   that drives the output (buffer read, then output reg).
// Throughput: one item per cycle while results are taken; input stalls only when the
//   buffer-read stage and the result register are both full and the result is not taken.
// Reset: synchronous, active low; clears pointers, flags, sender state and valids, not RAMs.
`timescale 1ns / 1ps
`default_nettype none

module uart_rx_tx_ring_buffer_top #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input wire logic       clk,
  input wire logic       rst_n,
  uart_rb_in_if.sink     in_if,
  uart_rb_out_if.source  out_if
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(BUFFER_DEPTH - 1);

  typedef logic [AW-1:0] ptr_t;

  function automatic ptr_t next_slot(input ptr_t idx);
    ptr_t n;
    n = (idx == LastSlot) ? '0 : idx + 1'b1;
    return n;
  endfunction

  // architectural state
  ptr_t                rx_head_r, rx_head_nxt;
  ptr_t                rx_tail_r, rx_tail_nxt;
  ptr_t                tx_head_r, tx_head_nxt;
  ptr_t                tx_tail_r, tx_tail_nxt;
  uart_rb_pkg::flags_t err_r, err_nxt;
  logic                sending_r, sending_nxt;

  // buffer-read stage and result register
  logic                s1_valid_r;
  uart_rb_pkg::stage_t s1_r, s1_nxt;
  logic                out_valid_r;
  uart_rb_pkg::stage_t out_r;
  uart_rb_pkg::byte_t  out_rd_r, out_ld_r;

  logic in_fire, s1_go;
  ptr_t rx_slot, rx_rslot, tx_slot, tx_rslot;
  logic rx_full, rx_empty, tx_full, tx_empty;

  logic               rx_we, rx_re, tx_we, tx_re;
  uart_rb_pkg::byte_t rx_rdata, tx_rdata;
  uart_rb_pkg::flags_t line_err;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_go;
  assign in_fire  = in_if.valid && in_if.ready;

  assign rx_slot  = next_slot(rx_head_r);
  assign rx_rslot = next_slot(rx_tail_r);
  assign tx_slot  = next_slot(tx_head_r);
  assign tx_rslot = next_slot(tx_tail_r);
  assign rx_full  = (rx_slot == rx_tail_r);
  assign rx_empty = (rx_head_r == rx_tail_r);
  assign tx_full  = (tx_slot == tx_tail_r);
  assign tx_empty = (tx_head_r == tx_tail_r);

  assign line_err = {1'b0, in_if.line_parity_error, in_if.line_overrun,
                     in_if.line_frame_error};

  always_comb begin
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    err_nxt     = err_r;
    sending_nxt = sending_r;
    rx_we = 1'b0;
    rx_re = 1'b0;
    tx_we = 1'b0;
    tx_re = 1'b0;
    s1_nxt = '0;
    if (in_fire) begin
      case (in_if.action)
        uart_rb_pkg::ACT_RX_BYTE: begin
          if (rx_full) begin
            err_nxt[uart_rb_pkg::FlagOverflow] = 1'b1;
          end else begin
            rx_we       = 1'b1;
            rx_head_nxt = rx_slot;
            err_nxt     = err_r | line_err;
          end
        end
        uart_rb_pkg::ACT_HOST_READ: begin
          if (rx_empty) begin
            s1_nxt.no_data = 1'b1;
          end else begin
            rx_re             = 1'b1;
            rx_tail_nxt       = rx_rslot;
            s1_nxt.read_valid = 1'b1;
            s1_nxt.flags      = err_r;
            err_nxt           = '0;
          end
        end
        uart_rb_pkg::ACT_HOST_WRITE: begin
          if (!tx_full) begin
            tx_we                 = 1'b1;
            tx_head_nxt           = tx_slot;
            sending_nxt           = 1'b1;
            s1_nxt.write_accepted = 1'b1;
          end
        end
        uart_rb_pkg::ACT_TX_READY: begin
          if (!tx_empty) begin
            tx_re             = 1'b1;
            tx_tail_nxt       = tx_rslot;
            s1_nxt.line_valid = 1'b1;
          end else begin
            sending_nxt = 1'b0;
          end
        end
        default: begin
          s1_nxt = '0;
        end
      endcase
      s1_nxt.sender_active = sending_nxt;
    end
  end

  uart_rb_ram #(
    .WIDTH (uart_rb_pkg::ByteW),
    .DEPTH (BUFFER_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_slot),
    .wdata (in_if.data_byte),
    .re    (rx_re),
    .raddr (rx_rslot),
    .rdata (rx_rdata)
  );

  uart_rb_ram #(
    .WIDTH (uart_rb_pkg::ByteW),
    .DEPTH (BUFFER_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_slot),
    .wdata (in_if.data_byte),
    .re    (tx_re),
    .raddr (tx_rslot),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      err_r       <= '0;
      sending_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
      err_r     <= err_nxt;
      sending_r <= sending_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_go) begin
      out_r    <= s1_r;
      out_rd_r <= s1_r.read_valid ? rx_rdata : '0;
      out_ld_r <= s1_r.line_valid ? tx_rdata : '0;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.read_valid     = out_r.read_valid;
  assign out_if.no_data        = out_r.no_data;
  assign out_if.read_data      = out_rd_r;
  assign out_if.frame_flag     = out_r.flags[uart_rb_pkg::FlagFrame];
  assign out_if.overrun_flag   = out_r.flags[uart_rb_pkg::FlagOverrun];
  assign out_if.parity_flag    = out_r.flags[uart_rb_pkg::FlagParity];
  assign out_if.overflow_flag  = out_r.flags[uart_rb_pkg::FlagOverflow];
  assign out_if.line_valid     = out_r.line_valid;
  assign out_if.line_data      = out_ld_r;
  assign out_if.write_accepted = out_r.write_accepted;
  assign out_if.sender_active  = out_r.sender_active;

`ifndef SYNTHESIS
  // buffer read data must hold while the stage waits on the result register
  a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> ($stable(rx_rdata) && $stable(tx_rdata)))
    else $error("buffer read data changed while stage stalled");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> s1_valid_r)
    else $error("stalled stage item lost");

  a_full_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.action == uart_rb_pkg::ACT_HOST_WRITE && tx_full)
      |=> $stable(tx_head_r))
    else $error("refused host write moved transmit head");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.action == uart_rb_pkg::ACT_HOST_READ && !rx_empty) |=> (err_r == '0))
    else $error("host read did not clear collected flags");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.read_valid) |-> (out_if.read_data == '0 &&
      !out_if.frame_flag && !out_if.overrun_flag && !out_if.parity_flag &&
      !out_if.overflow_flag))
    else $error("read fields nonzero without a popped byte");
`endif

endmodule

`default_nettype wire

// ----- tb/uart_rx_tx_ring_buffer_top_tb.sv -----
// Self-checking testbench for the UART receive/transmit ring buffer pair.
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffer_top_tb;

  localparam int unsigned Depth = 64;
  localparam int unsigned TargetItems = 950;

  typedef struct packed {
    logic                rd_ok;
    logic                rd_empty;
    uart_rb_pkg::byte_t  rd_byte;
    uart_rb_pkg::flags_t rd_flags;
    logic                tx_ok;
    uart_rb_pkg::byte_t  tx_byte;
    logic                wr_ok;
    logic                tx_running;
  } reply_t;

  logic clk;
  logic rst_n;

  uart_rb_in_if  ev_ch ();
  uart_rb_out_if rs_ch ();

  uart_rx_tx_ring_buffer_top #(.BUFFER_DEPTH(Depth)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (ev_ch),
    .out_if (rs_ch)
  );

  // predictor state
  uart_rb_pkg::byte_t  rx_mem [Depth];
  uart_rb_pkg::byte_t  tx_mem [Depth];
  int unsigned         rx_wptr, rx_rptr, tx_wptr, tx_rptr;
  uart_rb_pkg::flags_t err_sticky;
  logic                tx_running;

  reply_t      replies_due [$];
  int unsigned mismatches;
  int unsigned n_sent;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned rx_hold_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned slot_after(int unsigned p);
    return (p == Depth - 1) ? 0 : p + 1;
  endfunction

  function automatic void predict_reply(uart_rb_pkg::action_t act, uart_rb_pkg::byte_t data,
                                        uart_rb_pkg::flags_t line_err, output reply_t r);
    int unsigned nxt;
    r = '0;
    case (act)
      uart_rb_pkg::ACT_RX_BYTE: begin
        nxt = slot_after(rx_wptr);
        if (nxt == rx_rptr) begin
          // byte dropped, line flags ignored
          err_sticky[uart_rb_pkg::FlagOverflow] = 1'b1;
        end else begin
          rx_mem[nxt] = data;
          rx_wptr = nxt;
          err_sticky = err_sticky | line_err;
        end
      end
      uart_rb_pkg::ACT_HOST_READ: begin
        if (rx_wptr == rx_rptr) begin
          r.rd_empty = 1'b1;
        end else begin
          rx_rptr = slot_after(rx_rptr);
          r.rd_ok = 1'b1;
          r.rd_byte = rx_mem[rx_rptr];
          r.rd_flags = err_sticky;
          err_sticky = '0;
        end
      end
      uart_rb_pkg::ACT_HOST_WRITE: begin
        nxt = slot_after(tx_wptr);
        if (nxt != tx_rptr) begin
          tx_mem[nxt] = data;
          tx_wptr = nxt;
          tx_running = 1'b1;
          r.wr_ok = 1'b1;
        end
      end
      default: begin
        if (tx_wptr != tx_rptr) begin
          tx_rptr = slot_after(tx_rptr);
          r.tx_ok = 1'b1;
          r.tx_byte = tx_mem[tx_rptr];
        end else begin
          tx_running = 1'b0;
        end
      end
    endcase
    r.tx_running = tx_running;
  endfunction

  // drive one event at the falling edge and hold it until the transfer
  task automatic send_event(uart_rb_pkg::action_t act, uart_rb_pkg::byte_t data, logic fe,
                            logic ov, logic pe);
    reply_t r;
    uart_rb_pkg::flags_t e;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      ev_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ev_ch.valid             <= 1'b1;
    ev_ch.action            <= act;
    ev_ch.data_byte         <= data;
    ev_ch.line_frame_error  <= fe;
    ev_ch.line_overrun      <= ov;
    ev_ch.line_parity_error <= pe;
    do @(posedge clk); while (ev_ch.ready !== 1'b1);
    e = '0;
    e[uart_rb_pkg::FlagFrame]   = fe;
    e[uart_rb_pkg::FlagOverrun] = ov;
    e[uart_rb_pkg::FlagParity]  = pe;
    predict_reply(act, data, e, r);
    replies_due.push_back(r);
    n_sent++;
  endtask

  task automatic send_line_byte(uart_rb_pkg::byte_t data);
    send_event(uart_rb_pkg::ACT_RX_BYTE, data, $urandom_range(3) == 0,
               $urandom_range(3) == 0, $urandom_range(3) == 0);
  endtask

  task automatic test_empty_buffers;
    send_event(uart_rb_pkg::ACT_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_TX_READY, 8'hFF, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_receive_flags;
    send_event(uart_rb_pkg::ACT_RX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_RX_BYTE, 8'hFF, 1'b1, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_RX_BYTE, 8'h5A, 1'b0, 1'b1, 1'b0);
    send_event(uart_rb_pkg::ACT_RX_BYTE, 8'hA5, 1'b1, 1'b1, 1'b1);
    send_event(uart_rb_pkg::ACT_HOST_READ, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_event(uart_rb_pkg::ACT_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_RX_BYTE, 8'h3C, 1'b0, 1'b0, 1'b1);
    repeat (4) send_event(uart_rb_pkg::ACT_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_transmit_path;
    send_event(uart_rb_pkg::ACT_HOST_WRITE, 8'h00, 1'b1, 1'b0, 1'b1);
    send_event(uart_rb_pkg::ACT_HOST_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_HOST_WRITE, 8'h81, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
    // empty: sender stops, then stays stopped
    send_event(uart_rb_pkg::ACT_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_buffers_full;
    repeat (Depth - 1) send_line_byte(uart_rb_pkg::byte_t'($urandom_range(255)));
    // overflow: flags on these bytes must not show up
    send_event(uart_rb_pkg::ACT_RX_BYTE, 8'hEE, 1'b1, 1'b1, 1'b1);
    send_event(uart_rb_pkg::ACT_RX_BYTE, 8'h11, 1'b1, 1'b1, 1'b1);
    repeat (Depth) send_event(uart_rb_pkg::ACT_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    repeat (Depth - 1) send_event(uart_rb_pkg::ACT_HOST_WRITE,
                                  uart_rb_pkg::byte_t'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_HOST_WRITE, 8'hDE, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_HOST_WRITE, 8'hAD, 1'b0, 1'b0, 1'b0);
    send_event(uart_rb_pkg::ACT_HOST_WRITE, 8'hBE, 1'b0, 1'b0, 1'b0);
    repeat (Depth + 1) send_event(uart_rb_pkg::ACT_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  // segments with skewed action mix so both buffers swing between empty and full
  task automatic test_random_traffic(int unsigned count);
    int unsigned w [4];
    int unsigned total, pick, seg, k;
    uart_rb_pkg::action_t act;
    k = 0;
    while (k < count) begin
      for (int i = 0; i < 4; i++) w[i] = $urandom_range(9) + 1;
      if ($urandom_range(1)) w[$urandom_range(3)] += 30;
      total = w[0] + w[1] + w[2] + w[3];
      seg = $urandom_range(80, 20);
      for (int j = 0; j < seg && k < count; j++) begin
        pick = $urandom_range(total - 1);
        if (pick < w[0]) act = uart_rb_pkg::ACT_RX_BYTE;
        else if (pick < w[0] + w[1]) act = uart_rb_pkg::ACT_HOST_READ;
        else if (pick < w[0] + w[1] + w[2]) act = uart_rb_pkg::ACT_HOST_WRITE;
        else act = uart_rb_pkg::ACT_TX_READY;
        if (act == uart_rb_pkg::ACT_RX_BYTE)
          send_line_byte(uart_rb_pkg::byte_t'($urandom_range(255)));
        else send_event(act, uart_rb_pkg::byte_t'($urandom_range(255)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
        k++;
      end
    end
  endtask

  // result side stalls for a long stretch while events keep coming
  task automatic test_backpressure;
    rx_hold_left = 200;
    repeat (20) send_line_byte(uart_rb_pkg::byte_t'($urandom_range(255)));
    repeat (20) send_event(uart_rb_pkg::ACT_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  // result ready, changed at the falling edge
  initial begin
    rs_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rs_ch.ready <= 1'b0;
      end else begin
        rs_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && rs_ch.valid === 1'b1 && rs_ch.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transfer with nothing outstanding");
      end else begin
        want = replies_due.pop_front();
        check_field("read_valid", 8'(want.rd_ok), 8'(rs_ch.read_valid));
        check_field("no_data", 8'(want.rd_empty), 8'(rs_ch.no_data));
        check_field("read_data", want.rd_byte, rs_ch.read_data);
        check_field("frame_flag", 8'(want.rd_flags[uart_rb_pkg::FlagFrame]),
                    8'(rs_ch.frame_flag));
        check_field("overrun_flag", 8'(want.rd_flags[uart_rb_pkg::FlagOverrun]),
                    8'(rs_ch.overrun_flag));
        check_field("parity_flag", 8'(want.rd_flags[uart_rb_pkg::FlagParity]),
                    8'(rs_ch.parity_flag));
        check_field("overflow_flag", 8'(want.rd_flags[uart_rb_pkg::FlagOverflow]),
                    8'(rs_ch.overflow_flag));
        check_field("line_valid", 8'(want.tx_ok), 8'(rs_ch.line_valid));
        check_field("line_data", want.tx_byte, rs_ch.line_data);
        check_field("write_accepted", 8'(want.wr_ok), 8'(rs_ch.write_accepted));
        check_field("sender_active", 8'(want.tx_running), 8'(rs_ch.sender_active));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    ev_ch.valid = 1'b0;
    ev_ch.action = uart_rb_pkg::ACT_RX_BYTE;
    ev_ch.data_byte = '0;
    ev_ch.line_frame_error = 1'b0;
    ev_ch.line_overrun = 1'b0;
    ev_ch.line_parity_error = 1'b0;
    rx_wptr = 0;
    rx_rptr = 0;
    tx_wptr = 0;
    tx_rptr = 0;
    err_sticky = '0;
    tx_running = 1'b0;
    mismatches = 0;
    n_sent = 0;
    rx_hold_left = 0;
    src_idle_pct = 9;
    snk_idle_pct = 83;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_buffers();
    test_receive_flags();
    test_transmit_path();
    test_buffers_full();
    test_random_traffic(250);

    src_idle_pct = 83;
    snk_idle_pct = 9;
    test_random_traffic(200);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_backpressure();
    test_random_traffic(TargetItems > n_sent ? TargetItems - n_sent : 0);

    @(negedge clk);
    ev_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
